FILE: rtl/psq_pkg.sv
// shared types and constants for the precharge and charge sequencer
`default_nettype none

package psq_pkg;

    localparam int unsigned MV_W      = 20;
    localparam int unsigned SCALED_W  = 24;
    localparam int unsigned CELL_W    = 16;
    localparam int unsigned CMD_W     = 16;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = 4'd15;

    localparam logic [CNT_W-1:0]  SETTLE_LIMIT_RST = 4'd3;
    localparam logic [CELL_W-1:0] CELL_FULL_RST    = 16'd4200;
    localparam logic [CMD_W-1:0]  VOLT_SET_RST     = 16'd420;
    localparam logic [CMD_W-1:0]  AMPS_SET_RST     = 16'd50;

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_FULL    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_SET     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPS_SET     = 4'd3;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_PRECHARGE = 2'd1,
        MODE_ACTIVE    = 2'd2,
        MODE_CHARGING  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [CNT_W-1:0]  settle_count;
        logic              pos_contactor;
    } seq_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]  settle_limit;
        logic [CELL_W-1:0] cell_full_mv;
        logic [CMD_W-1:0]  volt_set;
        logic [CMD_W-1:0]  amps_set;
    } seq_cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic              pos_contactor_close;
        logic              charger_on;
        logic [CMD_W-1:0]  charger_volts_cmd;
        logic [CMD_W-1:0]  charger_amps_cmd;
        logic              charge_done;
    } seq_result_t;

endpackage

`default_nettype wire

FILE: rtl/psq_step.sv
// one tick of the sequencer: next state and result from current state
`default_nettype none

module psq_step (
    input  wire psq_pkg::seq_state_t            cur,
    input  wire psq_pkg::seq_cfg_t              cfg,
    input  wire                                 neg_closed,
    input  wire                                 pin_level,
    input  wire [psq_pkg::SCALED_W-1:0]         pre_x10,
    input  wire [psq_pkg::SCALED_W-1:0]         pack_x9,
    input  wire [psq_pkg::CELL_W-1:0]           top_cell,
    output psq_pkg::seq_state_t                 nxt,
    output psq_pkg::seq_result_t                res
);
    import psq_pkg::*;

    mode_t pin_mode;
    logic  volt_ok;

    assign volt_ok = pre_x10 > pack_x9;

    // next state
    always_comb
    begin
        pin_mode = cur.mode;
        nxt      = cur;
        if (!pin_level && cur.mode == MODE_ACTIVE)
        begin
            pin_mode = MODE_CHARGING;
        end
        else if (pin_level && cur.mode == MODE_CHARGING)
        begin
            pin_mode = MODE_ACTIVE;
        end
        if (pin_mode == MODE_IDLE && neg_closed)
        begin
            pin_mode = MODE_PRECHARGE;
        end
        nxt.mode = pin_mode;
        if (pin_mode == MODE_PRECHARGE)
        begin
            priority if (volt_ok && cur.settle_count > cfg.settle_limit)
            begin
                nxt.pos_contactor = 1'b1;
                nxt.mode          = MODE_ACTIVE;
            end
            else if (neg_closed && volt_ok)
            begin
                if (cur.settle_count < COUNT_MAX)
                begin
                    nxt.settle_count = cur.settle_count + 1'b1;
                end
            end
            else
            begin
                nxt.pos_contactor = 1'b0;
                nxt.settle_count  = '0;
            end
        end
    end

    // outputs from the updated state
    always_comb
    begin
        res.mode                = nxt.mode;
        res.pos_contactor_close = nxt.pos_contactor;
        res.charger_on          = 1'b0;
        res.charger_volts_cmd   = '0;
        res.charger_amps_cmd    = '0;
        res.charge_done         = 1'b0;
        if (nxt.mode == MODE_CHARGING)
        begin
            res.charger_on        = 1'b1;
            res.charger_volts_cmd = cfg.volt_set;
            res.charger_amps_cmd  = cfg.amps_set;
            res.charge_done       = top_cell > cfg.cell_full_mv;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/precharge_charge_sequencer_top.sv
// top level of the precharge and charge sequencer
// an accepted transaction passes the input register and then the result register to the output port
// throughput: one transaction per cycle while the output is not stalled, set by the single tick update stage
// input register holds scaled voltages, result register feeds the output port
// reset (async, active low): idle mode, counter zero, contactor open,
// configuration back to defaults, both pipeline stages empty
`default_nettype none

module precharge_charge_sequencer_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration write port
    input  wire                                 cfg_we,
    input  wire [psq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [psq_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 neg_contactor_closed,
    input  wire                                 charge_pin_level,
    input  wire [psq_pkg::MV_W-1:0]             precharge_mv,
    input  wire [psq_pkg::MV_W-1:0]             pack_mv,
    input  wire [psq_pkg::CELL_W-1:0]           top_cell_mv,
    // output channel
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [1:0]                          mode,
    output logic                                pos_contactor_close,
    output logic                                charger_on,
    output logic [psq_pkg::CMD_W-1:0]           charger_volts_cmd,
    output logic [psq_pkg::CMD_W-1:0]           charger_amps_cmd,
    output logic                                charge_done
);
    import psq_pkg::*;

    // configuration registers
    seq_cfg_t    cfg_reg;

    // sequencer state
    seq_state_t  state_reg;
    seq_state_t  state_next;

    // input stage: payload held with voltages already scaled for the 90% test
    logic                 s1_valid_reg;
    logic                 s1_neg_reg;
    logic                 s1_pin_reg;
    logic [SCALED_W-1:0]  s1_pre_x10_reg;
    logic [SCALED_W-1:0]  s1_pack_x9_reg;
    logic [CELL_W-1:0]    s1_top_reg;

    // result stage
    logic                 out_valid_reg;
    seq_result_t          res_reg;
    seq_result_t          res_next;

    logic                 advance;
    logic                 in_take;
    logic [SCALED_W-1:0]  pre_ext;
    logic [SCALED_W-1:0]  pack_ext;

    // the input stage moves on whenever the result register is free or drains
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // 10 * precharge versus 9 * pack, done as shift and add
    assign pre_ext  = SCALED_W'(precharge_mv);
    assign pack_ext = SCALED_W'(pack_mv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_limit <= SETTLE_LIMIT_RST;
            cfg_reg.cell_full_mv <= CELL_FULL_RST;
            cfg_reg.volt_set     <= VOLT_SET_RST;
            cfg_reg.amps_set     <= AMPS_SET_RST;
        end
        else if (cfg_we)
        begin
            // writes past the last register are dropped
            unique case (cfg_index)
                CFG_SETTLE_LIMIT: cfg_reg.settle_limit <= cfg_data[CNT_W-1:0];
                CFG_CELL_FULL:    cfg_reg.cell_full_mv <= cfg_data[CELL_W-1:0];
                CFG_VOLT_SET:     cfg_reg.volt_set     <= cfg_data[CMD_W-1:0];
                CFG_AMPS_SET:     cfg_reg.amps_set     <= cfg_data[CMD_W-1:0];
                default:          ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_neg_reg     <= neg_contactor_closed;
            s1_pin_reg     <= charge_pin_level;
            s1_pre_x10_reg <= (pre_ext << 3) + (pre_ext << 1);
            s1_pack_x9_reg <= (pack_ext << 3) + pack_ext;
            s1_top_reg     <= top_cell_mv;
        end
    end

    // one tick of the precharge and charge rules
    psq_step u_step (
        .cur        (state_reg),
        .cfg        (cfg_reg),
        .neg_closed (s1_neg_reg),
        .pin_level  (s1_pin_reg),
        .pre_x10    (s1_pre_x10_reg),
        .pack_x9    (s1_pack_x9_reg),
        .top_cell   (s1_top_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // state commits only when the transaction moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode          <= MODE_IDLE;
            state_reg.settle_count  <= '0;
            state_reg.pos_contactor <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign mode                = res_reg.mode;
    assign pos_contactor_close = res_reg.pos_contactor_close;
    assign charger_on          = res_reg.charger_on;
    assign charger_volts_cmd   = res_reg.charger_volts_cmd;
    assign charger_amps_cmd    = res_reg.charger_amps_cmd;
    assign charge_done         = res_reg.charge_done;

endmodule

`default_nettype wire
